// ===== rtl/asp_pkg.sv =====
package asp_pkg;

	// field widths
	localparam int ID_W    = 16;
	localparam int PRIO_W  = 4;
	localparam int COUNT_W = 5;

	localparam logic [PRIO_W-1:0] MAX_PRIORITY = 4'd10;

	// action codes
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_BAD_PRIO = 2'd2;
	localparam logic [1:0] STATUS_FULL     = 2'd3;

	typedef struct packed {
		logic              action;
		logic [ID_W-1:0]   process_id;
		logic [PRIO_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]    out_process_id;
		logic [1:0]         status;
		logic [COUNT_W-1:0] queue_count;
	} rsp_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

endpackage

// ===== rtl/aging_priority_scheduler.sv =====
// Sorted process queue with priority aging. A request transfers at a rising
// edge with start high and busy low; busy then stays high for one cycle while
// every slot compares, ages and shifts at once, and done marks the result for
// exactly one cycle, raised by done_q after the exec state, so no new request
// is taken while busy is high. The result cannot be held off: it must be taken
// in the cycle that done is high. queue_count shows the count after the
// request, truncated to five bits for depths above 31.
module aging_priority_scheduler #(
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  asp_pkg::req_t   req,
	output logic            done,
	output asp_pkg::rsp_t   rsp
);

	asp_pkg::ctl_cmd_t cmd;

	asp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	asp_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/asp_ctrl.sv =====
module asp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output asp_pkg::ctl_cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	assign busy     = (state_q == ST_EXEC);
	assign done     = done_q;
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.exec = (state_q == ST_EXEC);

	// state sequencing and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/asp_datapath.sv =====
module asp_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  asp_pkg::ctl_cmd_t   cmd,
	input  asp_pkg::req_t       req,
	output asp_pkg::rsp_t       rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	asp_pkg::req_t req_q;
	asp_pkg::rsp_t rsp_q;

	logic [asp_pkg::ID_W-1:0]   ids_q   [DEPTH];
	logic [asp_pkg::PRIO_W-1:0] prios_q [DEPTH];
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_next;

	logic [DEPTH-1:0] stop;
	logic             do_enq;
	logic             do_deq;
	logic [1:0]       status;

	assign rsp = rsp_q;

	// per-slot compare and request decode
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			stop[i] = (CW'(i) >= count_q) || (prios_q[i] < req_q.priority_req);
		end
		do_enq     = 1'b0;
		do_deq     = 1'b0;
		status     = asp_pkg::STATUS_OK;
		count_next = count_q;
		if (req_q.action == asp_pkg::ACT_DEQUEUE) begin
			if (count_q == '0) begin
				status = asp_pkg::STATUS_EMPTY;
			end else begin
				do_deq     = 1'b1;
				count_next = count_q - CW'(1);
			end
		end else if (req_q.priority_req > asp_pkg::MAX_PRIORITY) begin
			status = asp_pkg::STATUS_BAD_PRIO;
		end else if (count_q == CW'(DEPTH)) begin
			status = asp_pkg::STATUS_FULL;
		end else begin
			do_enq     = 1'b1;
			count_next = count_q + CW'(1);
		end
	end

	// request capture on transfer
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_next;
		end
	end

	// slot row: shift towards the front on dequeue, insert and age on enqueue
	always_ff @(posedge clk) begin
		if (cmd.exec && do_deq) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				ids_q[i]   <= ids_q[i+1];
				prios_q[i] <= prios_q[i+1];
			end
		end else if (cmd.exec && do_enq) begin
			if (stop[0]) begin
				ids_q[0]   <= req_q.process_id;
				prios_q[0] <= req_q.priority_req;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (stop[i] && !stop[i-1]) begin
					ids_q[i]   <= req_q.process_id;
					prios_q[i] <= req_q.priority_req;
				end else if (stop[i-1] && (CW'(i - 1) < count_q)) begin
					ids_q[i]   <= ids_q[i-1];
					prios_q[i] <= prios_q[i-1] + asp_pkg::PRIO_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.out_process_id <= do_deq ? ids_q[0] : '0;
			rsp_q.status         <= status;
			rsp_q.queue_count    <= asp_pkg::COUNT_W'(count_next);
		end
	end

endmodule

// ===== rtl/asp_checker.sv =====
module asp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input asp_pkg::rsp_t   rsp
);

	// a transfer is followed by one busy cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

	// each transfer yields its result through the exec state and then done_q
	a_done_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result missing after transfer");

	// the result strobe lasts one cycle and never overlaps busy
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("result strobe malformed");

	// a failed request returns no process id
	a_err_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != asp_pkg::STATUS_OK) |-> rsp.out_process_id == '0)
		else $error("process id on failed request");

endmodule

bind aging_priority_scheduler asp_checker u_asp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ===== sim/tb_top.sv =====
import asp_pkg::*;

// tracks the sorted run queue and the responses that are still to come back
class ready_queue_tracker #(int DEPTH = 16);
	logic [ID_W-1:0]   slot_id   [DEPTH];
	logic [PRIO_W-1:0] slot_prio [DEPTH];
	int unsigned       entries;
	rsp_t              due_rsp [$];
	int unsigned       mismatch_count;

	function new();
		entries = 0;
		mismatch_count = 0;
	endfunction

	// apply one accepted request to the queue and queue up its response
	function void note_request(req_t r);
		rsp_t        want;
		int unsigned pos;
		want = '0;
		want.status = STATUS_OK;
		if (r.action == ACT_DEQUEUE) begin
			if (entries == 0) begin
				want.status = STATUS_EMPTY;
			end else begin
				want.out_process_id = slot_id[0];
				for (int k = 1; k < entries; k++) begin
					slot_id[k-1]   = slot_id[k];
					slot_prio[k-1] = slot_prio[k];
				end
				entries--;
			end
		end else if (r.priority_req > MAX_PRIORITY) begin
			want.status = STATUS_BAD_PRIO;
		end else if (entries >= DEPTH) begin
			want.status = STATUS_FULL;
		end else begin
			// first slot from the front with a lower priority
			pos = 0;
			while (pos < entries && slot_prio[pos] >= r.priority_req)
				pos++;
			// age the lower tail and shift it back by one
			for (int k = entries; k > pos; k--) begin
				slot_id[k]   = slot_id[k-1];
				slot_prio[k] = slot_prio[k-1] + 1'b1;
			end
			slot_id[pos]   = r.process_id;
			slot_prio[pos] = r.priority_req;
			entries++;
		end
		want.queue_count = entries[COUNT_W-1:0];
		due_rsp.push_back(want);
	endfunction

	// compare a response with the oldest outstanding one
	function void check_response(rsp_t got);
		rsp_t want;
		if (due_rsp.size() == 0) begin
			$error("response with no request outstanding: id %0h status %0d count %0d",
				got.out_process_id, got.status, got.queue_count);
			mismatch_count++;
			return;
		end
		want = due_rsp.pop_front();
		if (got.out_process_id !== want.out_process_id) begin
			$error("out_process_id: expected %0h, got %0h",
				want.out_process_id, got.out_process_id);
			mismatch_count++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatch_count++;
		end
		if (got.queue_count !== want.queue_count) begin
			$error("queue_count: expected %0d, got %0d", want.queue_count, got.queue_count);
			mismatch_count++;
		end
	endfunction
endclass

module tb_top;
	localparam int QUEUE_DEPTH    = 16;
	localparam int RANDOM_ITEMS   = 450;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	int unsigned idle_cycles = 0;
	int          fill_prio [16] = '{0, 10, 5, 5, 3, 10, 0, 7, 1, 9, 2, 8, 4, 6, 10, 0};

	ready_queue_tracker #(QUEUE_DEPTH) tracker;

	aging_priority_scheduler #(
		.DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one request transfer: hold start until the block is free
	task automatic transfer_request(input req_t r);
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		tracker.note_request(r);
	endtask

	task automatic send_fields(input logic act, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio);
		req_t r;
		r.action       = act;
		r.process_id   = id;
		r.priority_req = prio;
		transfer_request(r);
	endtask

	// gap between bursts
	task automatic hold_off(input int unsigned cycles);
		if (cycles != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_response(rsp);
	end

	// watchdog on cycles with no transfer in either direction
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("aging_priority_scheduler verification failed");
				$finish;
			end
		end
	end

	initial begin
		req_t        r;
		lean_t       lean;
		int unsigned deq_pct;
		int unsigned phase_len;
		int unsigned burst_left;
		int unsigned issued;

		tracker = new();
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty queue errors first
		send_fields(ACT_DEQUEUE, 16'hFFFF, 4'd15);
		send_fields(ACT_ENQUEUE, 16'h1234, 4'd11);
		// fill to the top with extreme ids, ties and both priority limits
		for (int k = 0; k < 16; k++) begin
			if (k == 0)
				send_fields(ACT_ENQUEUE, 16'h0000, PRIO_W'(fill_prio[k]));
			else if (k == 1)
				send_fields(ACT_ENQUEUE, 16'hFFFF, PRIO_W'(fill_prio[k]));
			else
				send_fields(ACT_ENQUEUE, ID_W'($urandom()), PRIO_W'(fill_prio[k]));
		end
		// full queue, then a bad priority while full
		send_fields(ACT_ENQUEUE, 16'hA5A5, 4'd5);
		send_fields(ACT_ENQUEUE, 16'h5A5A, 4'd15);
		send_fields(ACT_DEQUEUE, 16'h0000, 4'd0);
		send_fields(ACT_DEQUEUE, 16'hFFFF, 4'd10);
		send_fields(ACT_ENQUEUE, 16'h8001, 4'd10);

		// random phases leaning towards filling, draining or neither
		issued = 0;
		burst_left = $urandom_range(1, 10);
		while (issued < RANDOM_ITEMS) begin
			lean = lean_t'($urandom_range(0, 2));
			deq_pct = (lean == LEAN_FILL) ? 20 : (lean == LEAN_DRAIN) ? 80 : 50;
			phase_len = $urandom_range(20, 40);
			for (int i = 0; i < phase_len && issued < RANDOM_ITEMS; i++) begin
				r.action = ($urandom_range(0, 99) < deq_pct) ? ACT_DEQUEUE : ACT_ENQUEUE;
				r.process_id = ID_W'($urandom());
				if ($urandom_range(0, 11) == 0)
					r.priority_req = PRIO_W'($urandom_range(11, 15));
				else
					r.priority_req = PRIO_W'($urandom_range(0, 10));
				transfer_request(r);
				issued++;
				if (burst_left == 0) begin
					hold_off($urandom_range(0, 6));
					burst_left = $urandom_range(1, 10);
				end else begin
					burst_left--;
				end
			end
		end

		// let the last responses drain
		@(negedge clk);
		start <= 1'b0;
		while (tracker.due_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("aging_priority_scheduler verification clean");
		else
			$display("aging_priority_scheduler verification failed");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/asp_pkg.sv
rtl/asp_ctrl.sv
rtl/asp_datapath.sv
rtl/aging_priority_scheduler.sv
rtl/asp_checker.sv
sim/tb_top.sv
